// ----- rtl/hjc_pkg.sv -----
// Shared types and defaults for the Hangul jamo composer.
package hjc_pkg;

  localparam int unsigned QueueDepth = 4;

  // One input item's worth of output: one or two code points to encode.
  typedef struct packed {
    logic [20:0] cp0;
    logic [1:0]  len0;   // encoded length minus one
    logic [20:0] cp1;
    logic [1:0]  len1;
    logic        two;    // cp1 is present
  } entry_t;

endpackage

// ----- rtl/utf8_hangul_jamo_composer.sv -----
// Top level: UTF-8 byte stream in, Hangul-composed UTF-8 byte stream out.
// Takes one input byte per cycle while full is low and delivers one output
// byte per cycle while pop is held. Each input byte produces zero to seven
// output bytes; its last output byte carries last_of_run_o. The back end
// emits one byte per cycle while pop is held, so a byte that yields several
// output bytes occupies it until its last one is taken; the entry queue
// (Depth entries, one per byte that yields output) lets input keep flowing
// meanwhile, and full rises once it fills. An accepted byte's first output
// byte goes through the entry queue and then the back end's output register.
module utf8_hangul_jamo_composer #(
  parameter int unsigned Depth = hjc_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  hjc_pkg::entry_t wr_entry, rd_entry;
  logic            q_push, q_pop, q_empty;

  hjc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (full),
    .q_push_o      (q_push),
    .q_entry_o     (wr_entry)
  );

  hjc_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (rd_entry),
    .empty_o (q_empty)
  );

  hjc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (rd_entry),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/hjc_front.sv -----
// Front end: UTF-8 decoder and jamo composer, emits code point entries.
module hjc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_text_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output hjc_pkg::entry_t   q_entry_o
);

  localparam logic [15:0] SBase   = 16'hAC00;
  localparam logic [20:0] LFirst  = 21'h01100;
  localparam logic [20:0] LLast   = 21'h01112;
  localparam logic [20:0] VFirst  = 21'h01161;
  localparam logic [20:0] VLast   = 21'h01175;
  localparam logic [20:0] TFirst  = 21'h011A8;
  localparam logic [20:0] TLast   = 21'h011C2;
  localparam logic [7:0]  TBaseLo = 8'hA7;
  localparam logic [7:0]  VBaseLo = 8'h61;
  localparam logic [20:0] CpMax   = 21'h10FFFF;
  localparam logic [15:0] LStride = 16'd588;
  localparam logic [15:0] VStride = 16'd28;

  typedef enum logic [1:0] {
    P_NONE,
    P_L,
    P_LV
  } pend_e;

  logic [20:0] part_q, part_d;
  logic [1:0]  exp_q, exp_d;
  pend_e       pc_q, pc_d;
  logic [4:0]  lidx_q, lidx_d;
  logic [15:0] syl_q, syl_d;

  logic        accept;
  logic        take;
  logic [20:0] cp;
  logic [1:0]  exp_m1;
  logic        is_lead, is_medial, is_trail;
  logic [7:0]  t_off, v_off;
  logic [15:0] syl_new, syl_trail;
  logic        a_v, b_v, c_v, b_ok, x_v;
  logic [20:0] a_cp, b_cp, c_cp, x_cp;

  function automatic logic [1:0] enc_len(logic [20:0] c);
    if (c <= 21'h7F) begin
      return 2'd0;
    end else if (c <= 21'h7FF) begin
      return 2'd1;
    end else if (c <= 21'hFFFF) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  assign accept = push_i & ~q_full_i;
  assign exp_m1 = exp_q - 2'd1;

  // decoder
  always_comb begin
    part_d = part_q;
    exp_d  = exp_q;
    take   = 1'b0;
    cp     = '0;
    if (exp_q != 2'd0) begin
      unique case (exp_q)
        2'd3:    part_d = part_q | {3'b0, in_byte_i[5:0], 12'b0};
        2'd2:    part_d = part_q | {9'b0, in_byte_i[5:0], 6'b0};
        default: part_d = part_q | {15'b0, in_byte_i[5:0]};
      endcase
      exp_d = exp_m1;
      if (exp_m1 == 2'd0) begin
        take   = 1'b1;
        cp     = part_d;
        part_d = '0;
      end
    end else if (!in_byte_i[7]) begin
      take = 1'b1;
      cp   = {13'b0, in_byte_i};
    end else if (in_byte_i[7:5] == 3'b110) begin
      part_d = {10'b0, in_byte_i[4:0], 6'b0};
      exp_d  = 2'd1;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      part_d = {5'b0, in_byte_i[3:0], 12'b0};
      exp_d  = 2'd2;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      part_d = {in_byte_i[2:0], 18'b0};
      exp_d  = 2'd3;
    end else begin
      take = 1'b1;
      cp   = '0;
    end
    // truncated sequence at end of text: missing bits are zero
    if (end_of_text_i && exp_d != 2'd0) begin
      take   = 1'b1;
      cp     = part_d;
      exp_d  = 2'd0;
      part_d = '0;
    end
  end

  assign is_lead   = (cp >= LFirst) && (cp <= LLast);
  assign is_medial = (cp >= VFirst) && (cp <= VLast);
  assign is_trail  = (cp >= TFirst) && (cp <= TLast);
  assign t_off    = cp[7:0] - TBaseLo;
  assign v_off    = cp[7:0] - VBaseLo;
  assign syl_new  = SBase + 16'(lidx_q) * LStride + 16'(v_off[4:0]) * VStride;
  assign syl_trail = syl_q + 16'(t_off[4:0]);

  // composer: A is a flushed syllable or L, B the code point itself,
  // C a pending L or LV flushed at end of text (B and C never both occur)
  always_comb begin
    pc_d   = pc_q;
    lidx_d = lidx_q;
    syl_d  = syl_q;
    a_v    = 1'b0;
    a_cp   = '0;
    b_v    = 1'b0;
    b_cp   = cp;
    c_v    = 1'b0;
    c_cp   = '0;
    if (take) begin
      logic general;
      general = 1'b1;
      unique case (pc_q)
        P_LV: begin
          a_v  = 1'b1;
          pc_d = P_NONE;
          if (is_trail) begin
            a_cp    = {5'b0, syl_trail};
            general = 1'b0;
          end else begin
            a_cp = {5'b0, syl_q};
          end
        end
        P_L: begin
          if (is_medial) begin
            syl_d   = syl_new;
            pc_d    = P_LV;
            general = 1'b0;
          end else begin
            a_v  = 1'b1;
            a_cp = LFirst | {16'b0, lidx_q};
            pc_d = P_NONE;
          end
        end
        default: ;
      endcase
      if (general) begin
        if (is_lead) begin
          lidx_d = cp[4:0];
          pc_d   = P_L;
        end else begin
          b_v = 1'b1;
        end
      end
    end
    if (end_of_text_i) begin
      unique case (pc_d)
        P_L: begin
          c_v  = 1'b1;
          c_cp = LFirst | {16'b0, lidx_d};
        end
        P_LV: begin
          c_v  = 1'b1;
          c_cp = {5'b0, syl_d};
        end
        default: ;
      endcase
      pc_d = P_NONE;
    end
  end

  // code points above the Unicode range produce nothing
  assign b_ok = b_v && (b_cp <= CpMax);
  assign x_v  = b_ok | c_v;
  assign x_cp = b_ok ? b_cp : c_cp;

  always_comb begin
    if (a_v) begin
      q_entry_o.cp0 = a_cp;
      q_entry_o.two = x_v;
    end else begin
      q_entry_o.cp0 = x_cp;
      q_entry_o.two = 1'b0;
    end
    q_entry_o.cp1  = x_cp;
    q_entry_o.len0 = enc_len(q_entry_o.cp0);
    q_entry_o.len1 = enc_len(x_cp);
  end

  assign q_push_o = accept & (a_v | x_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      exp_q  <= '0;
      pc_q   <= P_NONE;
      lidx_q <= '0;
      syl_q  <= '0;
    end else if (accept) begin
      part_q <= part_d;
      exp_q  <= exp_d;
      pc_q   <= pc_d;
      lidx_q <= lidx_d;
      syl_q  <= syl_d;
    end
  end

endmodule

// ----- rtl/hjc_queue.sv -----
// Small FIFO of code point entries between front and back end.
module hjc_queue #(
  parameter int unsigned Depth = hjc_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hjc_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output hjc_pkg::entry_t rdata_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  hjc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/hjc_back.sv -----
// Back end: serializes queued code points into UTF-8 bytes.
module hjc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hjc_pkg::entry_t entry_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  logic        sel_q;
  logic [1:0]  bi_q;
  logic        out_vld_q;
  logic [7:0]  byte_q;
  logic        last_q;

  logic        adv, have;
  logic [20:0] cur_cp;
  logic [1:0]  cur_len;
  logic        cp_end, ent_end;
  logic [7:0]  cur_byte;

  function automatic logic [7:0] enc_byte(logic [20:0] c, logic [1:0] len_m1,
                                          logic [1:0] idx);
    logic [1:0] rem;
    logic [5:0] six;
    rem = len_m1 - idx;
    unique case (rem)
      2'd0:    six = c[5:0];
      2'd1:    six = c[11:6];
      2'd2:    six = c[17:12];
      default: six = {3'b0, c[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (len_m1)
        2'd0:    return {1'b0, c[6:0]};
        2'd1:    return {3'b110, c[10:6]};
        2'd2:    return {4'b1110, c[15:12]};
        default: return {5'b11110, c[20:18]};
      endcase
    end
    return {2'b10, six};
  endfunction

  assign adv      = ~out_vld_q | pop;
  assign have     = ~q_empty_i;
  assign cur_cp   = sel_q ? entry_i.cp1 : entry_i.cp0;
  assign cur_len  = sel_q ? entry_i.len1 : entry_i.len0;
  assign cur_byte = enc_byte(cur_cp, cur_len, bi_q);
  assign cp_end   = (bi_q == cur_len);
  assign ent_end  = cp_end & (sel_q | ~entry_i.two);
  assign q_pop_o  = adv & have & ent_end;

  assign empty         = ~out_vld_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= cur_byte;
      last_q <= ent_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 1'b0;
      bi_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= have;
      if (have) begin
        if (cp_end) begin
          bi_q  <= '0;
          sel_q <= ~ent_end;
        end else begin
          bi_q <= bi_q + 2'd1;
        end
      end
    end
  end

endmodule

// ----- bench/tb_utf8_hangul_jamo_composer.sv -----
// Self-checking testbench for utf8_hangul_jamo_composer: directed table plus random UTF-8 text.
module tb_utf8_hangul_jamo_composer;

  localparam int RandomItems = 260;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 24;

  typedef struct packed {
    logic [7:0]  data;
    logic        eot;
    logic        lit_on;   // expected output typed in below
    logic [2:0]  lit_n;
    logic [31:0] lit;      // first byte in [31:24]
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  utf8_hangul_jamo_composer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  // Reset values, extremes and error bytes carry their output in the table.
  stim_row_t directed [25] = '{
    '{8'h00, 1'b0, 1'b1, 3'd1, 32'h0000_0000},
    '{8'h7F, 1'b0, 1'b1, 3'd1, 32'h7F00_0000},
    '{8'h80, 1'b0, 1'b1, 3'd1, 32'h0000_0000},  // stray continuation
    '{8'hFF, 1'b0, 1'b1, 3'd1, 32'h0000_0000},  // invalid lead
    '{8'hC2, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 32'h0},
    // first lead, first vowel, first trail: one syllable
    '{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h84, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h85, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hA1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h86, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hA8, 1'b0, 1'b0, 3'd0, 32'h0},
    // last lead, last vowel, then end of text flushes the held pair
    '{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h84, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h92, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h85, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hB5, 1'b1, 1'b0, 3'd0, 32'h0},
    // cut short at end, above U+10FFFF: nothing comes out
    '{8'hF5, 1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h80, 1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h80, 1'b1, 1'b1, 3'd0, 32'h0},
    // lone four-byte lead at end completes with zero bits
    '{8'hF4, 1'b1, 1'b1, 3'd4, 32'hF480_8080}
  };

  stim_row_t stim [$];
  out_t      want [$];

  // composer model state
  logic [20:0] acc_cp    = '0;
  logic [1:0]  acc_need  = '0;
  logic [20:0] held_cp [2] = '{default: '0};
  logic [1:0]  held_cnt  = '0;
  logic [7:0]  run_b [7];
  int          run_n;

  int row_idx    = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int errors     = 0;
  int bytes_seen = 0;
  int n_syl      = 0;
  int n_eot      = 0;
  int cycles     = 0;
  int pop_age    = 0;
  logic [15:0] pop_pat = 16'hFFFF;
  out_t got_ref;

  function automatic logic [31:0] utf8_pack(input logic [20:0] cp, output int len);
    if (cp <= 21'h7F) begin
      len = 1;
      return {cp[7:0], 24'h0};
    end else if (cp <= 21'h7FF) begin
      len = 2;
      return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
    end else if (cp <= 21'hFFFF) begin
      len = 3;
      return {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
    end
    len = 4;
    return {5'h1E, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
  endfunction

  function automatic logic [20:0] syllable(input logic [20:0] l, v, t);
    return 21'(32'hAC00 + (l - 21'h1100) * 588 + (v - 21'h1161) * 28 + t);
  endfunction

  task put_out(input logic [7:0] b);
    if (run_n < 7) begin
      run_b[run_n] = b;
      run_n++;
    end
  endtask

  task encode_cp(input logic [20:0] cp);
    logic [31:0] packed_b;
    int len;
    if (cp <= 21'h10FFFF) begin
      packed_b = utf8_pack(cp, len);
      for (int k = 0; k < len; k++) put_out(packed_b[31 - 8 * k -: 8]);
    end
  endtask

  task take_cp(input logic [20:0] cp);
    if (held_cnt == 2'd2) begin
      held_cnt = 2'd0;
      n_syl++;
      if (cp >= 21'h11A8 && cp <= 21'h11C2) begin
        encode_cp(syllable(held_cp[0], held_cp[1], cp - 21'h11A7));
        return;
      end
      encode_cp(syllable(held_cp[0], held_cp[1], 21'h0));
    end else if (held_cnt == 2'd1) begin
      if (cp >= 21'h1161 && cp <= 21'h1175) begin
        held_cp[1] = cp;
        held_cnt = 2'd2;
        return;
      end
      held_cnt = 2'd0;
      encode_cp(held_cp[0]);
    end
    held_cnt = 2'd0;
    if (cp >= 21'h1100 && cp <= 21'h1112) begin
      held_cp[0] = cp;
      held_cnt = 2'd1;
    end else begin
      encode_cp(cp);
    end
  endtask

  // Output bytes caused by one input byte land in run_b[0 .. run_n-1].
  task compose_byte(input logic [7:0] c, input logic eot);
    int sh;
    run_n = 0;
    if (acc_need != 2'd0) begin
      sh = 6 * (int'(acc_need) - 1);
      acc_cp = acc_cp | (21'(c[5:0]) << sh);
      acc_need--;
      if (acc_need == 2'd0) begin
        take_cp(acc_cp);
        acc_cp = '0;
      end
    end else if (c < 8'h80) begin
      take_cp({13'h0, c});
    end else if (c[7:5] == 3'b110) begin
      acc_cp = 21'(c[4:0]) << 6;
      acc_need = 2'd1;
    end else if (c[7:4] == 4'hE) begin
      acc_cp = 21'(c[3:0]) << 12;
      acc_need = 2'd2;
    end else if (c[7:3] == 5'h1E) begin
      acc_cp = 21'(c[2:0]) << 18;
      acc_need = 2'd3;
    end else begin
      take_cp(21'h0);
    end
    if (eot) begin
      if (acc_need != 2'd0) begin
        take_cp(acc_cp);
        acc_need = 2'd0;
        acc_cp = '0;
      end
      if (held_cnt == 2'd1) begin
        encode_cp(held_cp[0]);
      end else if (held_cnt == 2'd2) begin
        encode_cp(syllable(held_cp[0], held_cp[1], 21'h0));
        n_syl++;
      end
      held_cnt = 2'd0;
    end
  endtask

  task take_row(input stim_row_t r);
    compose_byte(r.data, r.eot);
    if (r.eot) n_eot++;
    if (r.lit_on) begin
      run_n = r.lit_n;
      for (int k = 0; k < run_n; k++) run_b[k] = r.lit[31 - 8 * k -: 8];
    end
    for (int k = 0; k < run_n; k++)
      want.insert(want.size(), out_t'{data: run_b[k], last: (k == run_n - 1)});
  endtask

  // Adds the first keep bytes of cp's encoding, end of text now and then.
  task add_cp(input logic [20:0] cp, input int keep);
    logic [31:0] packed_b;
    int len;
    packed_b = utf8_pack(cp, len);
    if (keep > len) keep = len;
    for (int k = 0; k < keep; k++)
      stim.insert(stim.size(), stim_row_t'{packed_b[31 - 8 * k -: 8],
                                           $urandom_range(13, 0) == 0,
                                           1'b0, 3'd0, 32'h0});
  endtask

  task build_random;
    int pick;
    while (stim.size() < $size(directed) + RandomItems) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)      add_cp(21'($urandom_range(32'h1113, 32'h10FF)), 4);
      else if (pick < 38) add_cp(21'($urandom_range(32'h1176, 32'h1160)), 4);
      else if (pick < 50) add_cp(21'($urandom_range(32'h11C3, 32'h11A7)), 4);
      else if (pick < 62) add_cp(21'($urandom_range(127, 0)), 4);
      else if (pick < 70) add_cp(21'($urandom_range(32'h7FF, 32'h80)), 4);
      else if (pick < 78) add_cp(21'($urandom_range(32'hFFFF, 32'h800)), 4);
      else if (pick < 85) add_cp(21'($urandom_range(32'h1FFFFF, 32'h10000)), 4);
      else if (pick < 94) begin
        stim.insert(stim.size(), stim_row_t'{8'($urandom), $urandom_range(9, 0) == 0,
                                             1'b0, 3'd0, 32'h0});
      end else begin
        // broken sequence: lead and at most two continuation bytes (complete if the code point is short)
        add_cp(21'($urandom_range(32'h1FFFFF, 32'h80)), $urandom_range(3, 1));
      end
    end
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        take_row(stim[row_idx]);
        row_idx++;
      end
      if (!push || !full) begin
        if (gap_left > 0 || row_idx >= stim.size()) begin
          push <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          push          <= 1'b1;
          in_byte_i     <= stim[row_idx].data;
          end_of_text_i <= stim[row_idx].eot;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: pop follows a rotating pattern that is swapped for a new one whenever pop_age wraps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (want.size() == 0) begin
          $display("%0t: unexpected output byte %02h last_of_run %0b",
                   $time, out_byte_o, last_of_run_o);
          errors++;
        end else begin
          got_ref = want.pop_front();
          bytes_seen++;
          if (out_byte_o !== got_ref.data) begin
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, got_ref.data, out_byte_o);
            errors++;
          end
          if (last_of_run_o !== got_ref.last) begin
            $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                     $time, got_ref.last, last_of_run_o);
            errors++;
          end
        end
      end
      pop_age++;
      if (pop_age == 48) begin
        pop_age = 0;
        case ($urandom_range(3, 0))
          0: pop_pat = 16'hFFFF;
          1: pop_pat = 16'($urandom);
          2: pop_pat = 16'h000F;
          default: pop_pat = 16'h5555;
        endcase
      end else begin
        pop_pat = {pop_pat[0], pop_pat[15:1]};
      end
      pop <= pop_pat[0];
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d bytes still expected",
               $time, cycles, want.size());
      $display("utf8_hangul_jamo_composer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    foreach (directed[i]) stim.insert(stim.size(), directed[i]);
    build_random();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (row_idx < stim.size() || want.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (want.size() != 0) begin
      $display("%0t: %0d expected output bytes never arrived", $time, want.size());
      errors++;
    end
    $display("sent %0d input bytes (%0d from the table), checked %0d output bytes",
             row_idx, $size(directed), bytes_seen);
    $display("%0d syllables composed, %0d end-of-text flushes, %0d errors",
             n_syl, n_eot, errors);
    if (errors == 0) begin
      $display("utf8_hangul_jamo_composer regression: pass");
    end else begin
      $display("utf8_hangul_jamo_composer regression: fail");
    end
    $finish;
  end

endmodule
